// ===== src/interval_timer_channel_core_defines.svh =====
// Shared assertion macros for the interval timer channel.
`ifndef INTERVAL_TIMER_CHANNEL_CORE_DEFINES_SVH
`define INTERVAL_TIMER_CHANNEL_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ITC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ITC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/itc_pkg.sv =====
package itc_pkg;

  typedef logic [1:0] req_t;
  typedef logic [1:0] port_t;
  typedef logic [7:0] byte_t;
  typedef logic [15:0] count_out_t;

  // request codes
  localparam req_t REQ_CMD  = 2'd0;
  localparam req_t REQ_DATA = 2'd1;
  localparam req_t REQ_TICK = 2'd2;

  // port offsets from the channel base
  localparam port_t PORT_DATA0 = 2'd0;
  localparam port_t PORT_CMD   = 2'd3;

  // accepted command bytes: channel 0, low/high access, binary
  localparam byte_t CMD_MODE0 = 8'h30;
  localparam byte_t CMD_MODE2 = 8'h34;

endpackage

// ===== src/itc_req_if.sv =====
interface itc_req_if;
  logic          valid;
  logic          ready;
  itc_pkg::req_t  req_type;
  itc_pkg::port_t port_sel;
  itc_pkg::byte_t write_byte;

  modport source (output valid, output req_type, output port_sel, output write_byte,
                  input ready);
  modport sink   (input valid, input req_type, input port_sel, input write_byte,
                  output ready);
endinterface

// ===== src/itc_res_if.sv =====
interface itc_res_if;
  logic                valid;
  logic                ready;
  logic                out_level;
  logic                irq_pulse;
  logic                cmd_reject;
  itc_pkg::count_out_t count_value;

  modport source (output valid, output out_level, output irq_pulse, output cmd_reject,
                  output count_value, input ready);
  modport sink   (input valid, input out_level, input irq_pulse, input cmd_reject,
                  input count_value, output ready);
endinterface

// ===== src/interval_timer_channel_core.sv =====
// Channel 0 of an interval timer. Each request item (command write, data write
// or one input clock tick) is taken and updates the channel state at the clock
// edge that accepts it; the result item for it appears in the result
// register on the following cycle. A new request item is accepted every cycle
// as long as the result register is empty or its item is being taken in the
// same cycle, so the sustained rate is one item per clock; the only thing that
// holds the request side back is a stalled result side. COUNT_BITS sets the
// width of the counter and reload value; count_value shows its low 16 bits,
// zero-extended when the counter is narrower.
`include "interval_timer_channel_core_defines.svh"

module interval_timer_channel_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  itc_req_if.sink       req,
  itc_res_if.source     res
);
  import itc_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_ZERO = '0;
  localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);

  // channel state
  logic                  rate_mode,      rate_mode_next;
  logic                  high_byte_due,  high_byte_due_next;
  byte_t                 low_byte_hold,  low_byte_hold_next;
  logic [COUNT_BITS-1:0] reload_value,   reload_value_next;
  logic [COUNT_BITS-1:0] down_counter,   down_counter_next;
  logic                  output_pin,     output_pin_next;
  logic                  counting,       counting_next;

  // result register
  logic                  res_valid;
  logic                  reject_next;
  logic                  irq_next;
  logic                  accept;

  logic [COUNT_BITS-1:0] count_dec;
  logic [31:0]           load_wide;
  logic [31:0]           count_wide;

  // The result register is free when empty or being drained this cycle.
  assign req.ready = !res_valid || res.ready;
  assign accept    = req.valid && req.ready;

  assign count_dec = down_counter - CNT_ONE;
  // Assemble the 16-bit load value, then fit it to the counter width.
  assign load_wide = {16'd0, req.write_byte, low_byte_hold};

  always_comb begin
    rate_mode_next     = rate_mode;
    high_byte_due_next = high_byte_due;
    low_byte_hold_next = low_byte_hold;
    reload_value_next  = reload_value;
    down_counter_next  = down_counter;
    output_pin_next    = output_pin;
    counting_next      = counting;
    reject_next        = 1'b0;

    case (req.req_type)
      REQ_CMD: begin
        // Only the two supported commands on the command port; a valid one
        // stops counting and re-arms the byte sequence.
        if (req.port_sel == PORT_CMD && req.write_byte inside {CMD_MODE0, CMD_MODE2}) begin
          rate_mode_next     = (req.write_byte == CMD_MODE2);
          counting_next      = 1'b0;
          high_byte_due_next = 1'b0;
          output_pin_next    = rate_mode_next;
        end else begin
          reject_next = 1'b1;
        end
      end
      REQ_DATA: begin
        if (req.port_sel != PORT_DATA0) begin
          reject_next = 1'b1;
        end else if (!high_byte_due) begin
          // Hold the low byte; mode 0 halts until the high byte lands.
          low_byte_hold_next = req.write_byte;
          high_byte_due_next = 1'b1;
          if (!rate_mode) begin
            counting_next = 1'b0;
          end
        end else begin
          // High byte completes the load and starts counting.
          high_byte_due_next = 1'b0;
          reload_value_next  = load_wide[COUNT_BITS-1:0];
          down_counter_next  = load_wide[COUNT_BITS-1:0];
          counting_next      = 1'b1;
          output_pin_next    = rate_mode;
        end
      end
      REQ_TICK: begin
        if (counting) begin
          if (!rate_mode) begin
            // Mode 0: advance, latch the output high at terminal count.
            down_counter_next = count_dec;
            if (count_dec == CNT_ZERO) begin
              output_pin_next = 1'b1;
            end
          end else if (down_counter == CNT_ONE) begin
            // Mode 2: reload after the low tick and raise the output.
            down_counter_next = reload_value;
            output_pin_next   = 1'b1;
          end else begin
            down_counter_next = count_dec;
            if (count_dec == CNT_ONE) begin
              output_pin_next = 1'b0;
            end
          end
        end
      end
      default: begin
        reject_next = 1'b1;
      end
    endcase
  end

  assign irq_next = !output_pin && output_pin_next;

  // State advances only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_mode     <= 1'b0;
      high_byte_due <= 1'b0;
      low_byte_hold <= '0;
      reload_value  <= '0;
      down_counter  <= '0;
      output_pin    <= 1'b0;
      counting      <= 1'b0;
    end else if (accept) begin
      rate_mode     <= rate_mode_next;
      high_byte_due <= high_byte_due_next;
      low_byte_hold <= low_byte_hold_next;
      reload_value  <= reload_value_next;
      down_counter  <= down_counter_next;
      output_pin    <= output_pin_next;
      counting      <= counting_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload: capture on accept, hold while stalled.
  assign count_wide = 32'(down_counter_next);

  always_ff @(posedge clk) begin
    if (accept) begin
      res.out_level   <= output_pin_next;
      res.irq_pulse   <= irq_next;
      res.cmd_reject  <= reject_next;
      res.count_value <= count_wide[15:0];
    end
  end

  assign res.valid = res_valid;

  // A pending result must never be overwritten by a new item.
  `ITC_ASSERT_NOW(a_no_overwrite, res_valid && !res.ready, !req.ready, "result overwritten")

  // A rejected item leaves the channel state untouched.
  `ITC_ASSERT_NEXT(a_reject_no_effect, accept && reject_next,
                   $stable(down_counter) && $stable(rate_mode) && $stable(output_pin)
                   && $stable(counting), "rejected item changed state")

  // A tick while stopped changes nothing.
  `ITC_ASSERT_NEXT(a_stopped_tick, accept && req.req_type == REQ_TICK && !counting,
                   $stable(down_counter) && $stable(output_pin), "stopped tick changed state")

  // A reported interrupt leaves the output pin high.
  `ITC_ASSERT_NEXT(a_irq_level, accept && irq_next,
                   output_pin && res.irq_pulse && res.out_level, "irq without high output")

endmodule
